// ===== rtl/x86e_pkg.sv =====
// Shared types and codes for the x86-64 encoder with label fixups.
package x86e_pkg;

    localparam logic [4:0] OP_NEW    = 5'd0;
    localparam logic [4:0] OP_BIND   = 5'd1;
    localparam logic [4:0] OP_JMP    = 5'd2;
    localparam logic [4:0] OP_JE     = 5'd3;
    localparam logic [4:0] OP_JNE    = 5'd4;
    localparam logic [4:0] OP_MOVABS = 5'd5;
    localparam logic [4:0] OP_MOV    = 5'd6;
    localparam logic [4:0] OP_ADD    = 5'd7;
    localparam logic [4:0] OP_SUB    = 5'd8;
    localparam logic [4:0] OP_IMUL   = 5'd9;
    localparam logic [4:0] OP_CMP    = 5'd10;
    localparam logic [4:0] OP_PUSH   = 5'd11;
    localparam logic [4:0] OP_POP    = 5'd12;
    localparam logic [4:0] OP_RET    = 5'd13;
    localparam logic [4:0] OP_PROL   = 5'd14;
    localparam logic [4:0] OP_EPIL   = 5'd15;
    localparam logic [4:0] OP_CHECK  = 5'd16;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_LABELS  = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_BOUND   = 3'd3;
    localparam logic [2:0] ST_PATCHES = 3'd4;
    localparam logic [2:0] ST_UNBOUND = 3'd5;
    localparam logic [2:0] ST_EARLIER = 3'd6;
    localparam logic [2:0] ST_FULL    = 3'd7;

    localparam logic [7:0] B_REX    = 8'h40;
    localparam logic [7:0] B_REXW   = 8'h08;
    localparam logic [7:0] B_MOVI   = 8'hB8;
    localparam logic [7:0] B_MOV    = 8'h89;
    localparam logic [7:0] B_ADD    = 8'h01;
    localparam logic [7:0] B_SUB    = 8'h29;
    localparam logic [7:0] B_IMUL   = 8'hAF;
    localparam logic [7:0] B_CMP    = 8'h39;
    localparam logic [7:0] B_JMP    = 8'hE9;
    localparam logic [7:0] B_JE     = 8'h84;
    localparam logic [7:0] B_JNE    = 8'h85;
    localparam logic [7:0] B_RET    = 8'hC3;
    localparam logic [7:0] B_ESC    = 8'h0F;
    localparam logic [7:0] B_PUSH   = 8'h50;
    localparam logic [7:0] B_POP    = 8'h58;
    localparam logic [7:0] B_PUSHBP = 8'h55;
    localparam logic [7:0] B_POPBP  = 8'h5D;
    localparam logic [7:0] B_ALUI   = 8'h81;

    typedef logic [10:0][7:0] t_bytes;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_EMIT,
        S_SRD,
        S_SLD
    } t_state;

endpackage

// ===== rtl/x86e_if.sv =====
// Request and result channel interfaces.
interface x86e_req_if;
    logic        valid;
    logic        ready;
    logic [4:0]  op;
    logic [3:0]  dst_reg;
    logic [3:0]  src_reg;
    logic [5:0]  target_id;
    logic signed [63:0] immediate;
    modport source (output valid, op, dst_reg, src_reg, target_id, immediate, input ready);
    modport sink (input valid, op, dst_reg, src_reg, target_id, immediate, output ready);
endinterface

interface x86e_res_if;
    logic        valid;
    logic        ready;
    logic        has_write;
    logic [15:0] write_offset;
    logic [7:0]  write_byte;
    logic [5:0]  new_label_id;
    logic [2:0]  status;
    logic        last;
    modport source (output valid, has_write, write_offset, write_byte, new_label_id,
                    status, last, input ready);
    modport sink (input valid, has_write, write_offset, write_byte, new_label_id,
                  status, last, output ready);
endinterface

// ===== rtl/x86e_encode.sv =====
// Byte image and length of the plain register and stack instructions.
module x86e_encode
    import x86e_pkg::*;
(
    input  logic [4:0]  i_op,
    input  logic [3:0]  i_dst,
    input  logic [3:0]  i_src,
    input  logic [63:0] i_imm,
    output t_bytes      o_bytes,
    output logic [3:0]  o_len
);
    logic [7:0] rex_sd, rex_ds, mod_sd, mod_ds, rex_d;

    assign rex_sd = B_REX | B_REXW | (i_src[3] ? 8'h04 : 8'h00) | (i_dst[3] ? 8'h01 : 8'h00);
    assign rex_ds = B_REX | B_REXW | (i_dst[3] ? 8'h04 : 8'h00) | (i_src[3] ? 8'h01 : 8'h00);
    assign rex_d  = B_REX | B_REXW | (i_dst[3] ? 8'h01 : 8'h00);
    assign mod_sd = {2'b11, i_src[2:0], i_dst[2:0]};
    assign mod_ds = {2'b11, i_dst[2:0], i_src[2:0]};

    always_comb begin
        o_bytes = '0;
        o_len   = 4'd3;
        unique case (i_op)
            OP_MOVABS: begin
                o_bytes[0]   = rex_d;
                o_bytes[1]   = B_MOVI + {5'd0, i_dst[2:0]};
                o_bytes[9:2] = i_imm;
                o_len        = 4'd10;
            end
            OP_MOV:  o_bytes[2:0] = {mod_sd, B_MOV, rex_sd};
            OP_ADD:  o_bytes[2:0] = {mod_sd, B_ADD, rex_sd};
            OP_SUB:  o_bytes[2:0] = {mod_sd, B_SUB, rex_sd};
            OP_CMP:  o_bytes[2:0] = {mod_sd, B_CMP, rex_sd};
            OP_IMUL: begin
                o_bytes[3:0] = {mod_ds, B_IMUL, B_ESC, rex_ds};
                o_len        = 4'd4;
            end
            OP_PUSH, OP_POP: begin
                if (i_dst[3]) begin
                    o_bytes[0] = B_REX | 8'h01;
                    o_bytes[1] = ((i_op == OP_PUSH) ? B_PUSH : B_POP) + {5'd0, i_dst[2:0]};
                    o_len      = 4'd2;
                end else begin
                    o_bytes[0] = ((i_op == OP_PUSH) ? B_PUSH : B_POP) + {5'd0, i_dst[2:0]};
                    o_len      = 4'd1;
                end
            end
            OP_RET: begin
                o_bytes[0] = B_RET;
                o_len      = 4'd1;
            end
            OP_PROL: begin
                o_bytes[3:0] = {8'hE5, B_MOV, B_REX | B_REXW, B_PUSHBP};
                if (i_imm != 64'd0) begin
                    o_bytes[6:4]  = {8'hEC, B_ALUI, B_REX | B_REXW};
                    o_bytes[10:7] = i_imm[31:0];
                    o_len         = 4'd11;
                end else begin
                    o_len = 4'd4;
                end
            end
            OP_EPIL: begin
                o_bytes[4:0] = {B_RET, B_POPBP, 8'hEC, B_MOV, B_REX | B_REXW};
                o_len        = 4'd5;
            end
            default: o_len = 4'd0;
        endcase
    end
endmodule

// ===== rtl/x86e_top_dummy_placeholder.sv =====
// Registered skid-free result holder between the sequencer and the result channel.
module x86e_outreg
    import x86e_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic        i_hw,
    input  logic [15:0] i_wofs,
    input  logic [7:0]  i_wb,
    input  logic [5:0]  i_nid,
    input  logic [2:0]  i_st,
    input  logic        i_last,
    output logic        o_free,
    x86e_res_if.source  o_res
);
    logic r_ov;
    assign o_free     = !r_ov || o_res.ready;
    assign o_res.valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            o_res.has_write    <= i_hw;
            o_res.write_offset <= i_wofs;
            o_res.write_byte   <= i_wb;
            o_res.new_label_id <= i_nid;
            o_res.status       <= i_st;
            o_res.last         <= i_last;
        end
    end
endmodule

// ===== rtl/x86_64_encoder_with_label_fixups_unit.sv =====
// Top level: assembler sequencer with label and fixup-site memories.
//
// One request enters on i_req; its byte writes leave on o_res in code order,
// one result per transaction, last set on the final one. A request that writes
// nothing gives one result with has_write low. Requests are taken one at a
// time: i_req.ready is high only while the sequencer is idle.
// Sequence: accept, with the label memory read as the request is taken, then
// decide in the look state, then one result byte per cycle while the output
// register is free. A bind with pending sites then walks them: each site is
// read from the site memory (a registered read) and its four rel32 bytes are
// emitted.
// The output register lets the last result wait while the next request is
// accepted; a stalled receiver holds the sequencer on its current byte.
// Reset clears the code offset, label count and error flag; the label and
// site memories need no clearing, since entries are written on creation.
module x86_64_encoder_with_label_fixups_unit
    import x86e_pkg::*;
#(
    parameter int LABEL_SLOTS     = 64,
    parameter int SITES_PER_LABEL = 8,
    parameter int CODE_BYTES      = 65536
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    x86e_req_if.sink   i_req,
    x86e_res_if.source o_res
);
    localparam int LW = (LABEL_SLOTS > 1) ? $clog2(LABEL_SLOTS) : 1;
    localparam int MW = $clog2(LABEL_SLOTS + 1);
    localparam int KW = (MW > 6) ? MW : 6;
    localparam int CW = $clog2(SITES_PER_LABEL + 1);
    localparam int AW = (LABEL_SLOTS * SITES_PER_LABEL > 1) ?
                        $clog2(LABEL_SLOTS * SITES_PER_LABEL) : 1;
    localparam int OW = $clog2(CODE_BYTES + 1);

    typedef struct packed {
        logic          bound;
        logic [OW-1:0] pos;
        logic [CW-1:0] cnt;
    } t_lab;

    t_lab          lab_mem [LABEL_SLOTS];
    logic [OW-1:0] site_mem [LABEL_SLOTS * SITES_PER_LABEL];

    t_state        r_state, n_state;
    logic [4:0]    r_op;
    logic [3:0]    r_dst, r_src;
    logic [5:0]    r_id;
    logic [63:0]   r_imm;
    logic [OW-1:0] r_code_ofs;
    logic [MW-1:0] r_labels, r_bound_cnt;
    logic          r_sticky;
    t_lab          r_lab_q;
    logic [OW-1:0] r_site_q;
    t_bytes        r_buf;
    logic [3:0]    r_len, r_idx;
    logic [OW-1:0] r_base;
    logic [2:0]    r_status;
    logic [5:0]    r_newid;
    logic [CW-1:0] r_cnt, r_si;
    logic          r_more;

    t_bytes        enc_bytes;
    logic [3:0]    enc_len;
    logic          out_free, emit, emit_end;

    logic [KW-1:0] id_ext, lab_ext;
    logic [LW-1:0] lab_idx, lab_raddr;
    logic          id_ok;
    t_bytes        lk_buf;
    logic [3:0]    lk_len;
    logic [2:0]    lk_status;
    logic [5:0]    lk_newid;
    logic          lk_sticky, lk_lab_we, lk_site_we, lk_new, lk_bind, lk_sites;
    logic [LW-1:0] lk_lab_addr;
    t_lab          lk_lab_data;
    logic [AW-1:0] lk_site_addr, site_raddr;
    logic [OW-1:0] lk_site_data;
    logic [31:0]   jl, rel, srel;

    x86e_encode u_enc (
        .i_op    (r_op),
        .i_dst   (r_dst),
        .i_src   (r_src),
        .i_imm   (r_imm),
        .o_bytes (enc_bytes),
        .o_len   (enc_len)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign emit        = (r_state == S_EMIT) && out_free;
    assign emit_end    = emit && ((r_len == 4'd0) || (r_idx == r_len - 4'd1));

    assign id_ext    = KW'(r_id);
    assign lab_ext   = KW'(r_labels);
    assign id_ok     = id_ext < lab_ext;
    assign lab_idx   = id_ext[LW-1:0];
    assign lab_raddr = LW'(i_req.target_id);
    assign site_raddr = AW'(32'(lab_idx) * SITES_PER_LABEL + 32'(r_si));
    assign jl        = (r_op == OP_JMP) ? 32'd1 : 32'd2;
    assign rel       = 32'(r_lab_q.pos) - (32'(r_code_ofs) + jl + 32'd4);
    assign srel      = 32'(r_code_ofs) - (32'(r_site_q) + 32'd4);

    always_ff @(posedge i_clk) begin
        r_lab_q  <= lab_mem[lab_raddr];
        r_site_q <= site_mem[site_raddr];
        if (lk_lab_we) begin
            lab_mem[lk_lab_addr] <= lk_lab_data;
        end
        if (lk_site_we) begin
            site_mem[lk_site_addr] <= lk_site_data;
        end
    end

    always_comb begin
        lk_buf       = '0;
        lk_len       = 4'd0;
        lk_status    = ST_OK;
        lk_newid     = 6'd0;
        lk_sticky    = 1'b0;
        lk_lab_we    = 1'b0;
        lk_site_we   = 1'b0;
        lk_new       = 1'b0;
        lk_bind      = 1'b0;
        lk_sites     = 1'b0;
        lk_lab_addr  = lab_idx;
        lk_lab_data  = r_lab_q;
        lk_site_addr = AW'(32'(lab_idx) * SITES_PER_LABEL + 32'(r_lab_q.cnt));
        lk_site_data = OW'(32'(r_code_ofs) + jl);
        if (r_state == S_LOOK) begin
            priority if (r_op == OP_NEW) begin
                if (lab_ext >= KW'(LABEL_SLOTS)) begin
                    lk_sticky = 1'b1;
                    lk_status = ST_LABELS;
                end else begin
                    lk_new      = 1'b1;
                    lk_newid    = lab_ext[5:0];
                    lk_lab_we   = 1'b1;
                    lk_lab_addr = lab_ext[LW-1:0];
                    lk_lab_data = '0;
                end
            end else if (r_op == OP_BIND) begin
                if (!id_ok) begin
                    lk_sticky = 1'b1;
                    lk_status = ST_INVALID;
                end else if (r_lab_q.bound) begin
                    lk_sticky = 1'b1;
                    lk_status = ST_BOUND;
                end else begin
                    lk_bind     = 1'b1;
                    lk_lab_we   = 1'b1;
                    lk_lab_data = '{bound: 1'b1, pos: r_code_ofs, cnt: '0};
                    lk_sites    = (r_lab_q.cnt != '0);
                end
            end else if (r_op == OP_JMP || r_op == OP_JE || r_op == OP_JNE) begin
                if (!id_ok) begin
                    lk_sticky = 1'b1;
                    lk_status = ST_INVALID;
                end else if (32'(r_code_ofs) + jl + 32'd4 > 32'(CODE_BYTES)) begin
                    lk_sticky = 1'b1;
                    lk_status = ST_FULL;
                end else begin
                    if (r_op == OP_JMP) begin
                        lk_buf[0] = B_JMP;
                    end else begin
                        lk_buf[0] = B_ESC;
                        lk_buf[1] = (r_op == OP_JE) ? B_JE : B_JNE;
                    end
                    if (r_lab_q.bound) begin
                        if (r_op == OP_JMP) lk_buf[4:1] = rel;
                        else lk_buf[5:2] = rel;
                        lk_len = 4'(jl + 32'd4);
                    end else if (32'(r_lab_q.cnt) >= SITES_PER_LABEL) begin
                        lk_sticky = 1'b1;
                        lk_status = ST_PATCHES;
                        lk_len    = 4'(jl);
                    end else begin
                        lk_site_we      = 1'b1;
                        lk_lab_we       = 1'b1;
                        lk_lab_data.cnt = r_lab_q.cnt + CW'(1);
                        lk_len          = 4'(jl + 32'd4);
                    end
                end
            end else if (r_op >= OP_MOVABS && r_op <= OP_EPIL) begin
                if (32'(r_code_ofs) + 32'(enc_len) > 32'(CODE_BYTES)) begin
                    lk_sticky = 1'b1;
                    lk_status = ST_FULL;
                end else begin
                    lk_buf = enc_bytes;
                    lk_len = enc_len;
                end
            end else if (r_op == OP_CHECK) begin
                if (r_sticky) begin
                    lk_status = ST_EARLIER;
                end else if (r_bound_cnt != r_labels) begin
                    lk_sticky = 1'b1;
                    lk_status = ST_UNBOUND;
                end
            end else begin
                lk_status = ST_OK;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_LOOK;
            S_LOOK: n_state = lk_sites ? S_SRD : S_EMIT;
            S_EMIT: if (emit_end) n_state = r_more ? S_SRD : S_IDLE;
            S_SRD:  n_state = S_SLD;
            S_SLD:  n_state = S_EMIT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_code_ofs  <= '0;
            r_labels    <= '0;
            r_bound_cnt <= '0;
            r_sticky    <= 1'b0;
            r_more      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_LOOK) begin
                r_code_ofs <= r_code_ofs + OW'(lk_len);
                if (lk_new) r_labels <= r_labels + MW'(1);
                if (lk_bind) r_bound_cnt <= r_bound_cnt + MW'(1);
                if (lk_sticky) r_sticky <= 1'b1;
                r_more <= 1'b0;
            end
            if (r_state == S_SLD) begin
                r_more <= (r_si + CW'(1) < r_cnt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op  <= i_req.op;
                r_dst <= i_req.dst_reg;
                r_src <= i_req.src_reg;
                r_id  <= i_req.target_id;
                r_imm <= i_req.immediate;
            end
            S_LOOK: begin
                r_buf    <= lk_buf;
                r_len    <= lk_len;
                r_idx    <= 4'd0;
                r_base   <= r_code_ofs;
                r_status <= lk_status;
                r_newid  <= lk_newid;
                r_cnt    <= r_lab_q.cnt;
                r_si     <= '0;
            end
            S_EMIT: begin
                if (emit) r_idx <= r_idx + 4'd1;
                if (emit_end) r_si <= r_si + CW'(1);
            end
            S_SRD: begin
            end
            S_SLD: begin
                r_buf[3:0] <= srel;
                r_len      <= 4'd4;
                r_idx      <= 4'd0;
                r_base     <= r_site_q;
            end
            default: begin
            end
        endcase
    end

    x86e_outreg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit),
        .i_hw    (r_len != 4'd0),
        .i_wofs  ((r_len != 4'd0) ? 16'(32'(r_base) + 32'(r_idx)) : 16'd0),
        .i_wb    ((r_len != 4'd0) ? r_buf[r_idx] : 8'd0),
        .i_nid   (r_newid),
        .i_st    (r_status),
        .i_last  (emit_end && !r_more),
        .o_free  (out_free),
        .o_res   (o_res)
    );

    a_ofs_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_code_ofs) <= 32'(CODE_BYTES))
        else $error("code offset beyond store");
    a_bound_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bound_cnt <= r_labels)
        else $error("more bound labels than created");
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_len <= 4'd11 && (r_len == 4'd0 || r_idx < r_len)))
        else $error("emit index out of range");
    a_sld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLD) |-> ($past(r_state) == S_SRD))
        else $error("site load without read");
endmodule
